// ===== hw/rtl/pkce_pkg.sv =====
// ----------------------------------------------------------------------------
// pkce_pkg
// Shared types and constants for the PIN-locked keypad command entry block.
// ----------------------------------------------------------------------------
package pkce_pkg;

  localparam int RADIX      = 10;
  localparam int PIN_DIGITS = 4;
  localparam int CMD_DIGITS = 3;

  localparam int VALUE_W = 14;
  localparam int CMDVAL_W = 10;
  localparam int KEY_W   = 4;
  localparam int MODE_W  = 3;

  // entry holds fewer than PIN_DIGITS digits below this value
  localparam int PIN_ROOM  = RADIX ** (PIN_DIGITS - 1);
  // at or above this value the next PIN digit is the last one
  localparam int PIN_LAST  = RADIX ** (PIN_DIGITS - 2);
  // command entry holds fewer than CMD_DIGITS digits below this value
  localparam int CMD_ROOM  = RADIX ** (CMD_DIGITS - 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOCKED = 3'd0,
    MODE_IDLE   = 3'd1,
    MODE_FWD    = 3'd2,
    MODE_RIGHT  = 3'd3,
    MODE_BACK   = 3'd4,
    MODE_LEFT   = 3'd5,
    MODE_SONAR  = 3'd6,
    MODE_SPRING = 3'd7
  } mode_t;

  localparam logic [KEY_W-1:0] KEY_SONAR  = 4'd5;
  localparam logic [KEY_W-1:0] KEY_SPRING = 4'd7;
  localparam logic [KEY_W-1:0] KEY_DIG_MAX = 4'd9;
  localparam logic [KEY_W-1:0] KEY_HASH   = 4'd10;
  localparam logic [KEY_W-1:0] KEY_OK     = 4'd11;
  localparam logic [KEY_W-1:0] KEY_UP     = 4'd12;
  localparam logic [KEY_W-1:0] KEY_RIGHT  = 4'd13;
  localparam logic [KEY_W-1:0] KEY_DOWN   = 4'd14;
  localparam logic [KEY_W-1:0] KEY_LEFT   = 4'd15;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_IDX_PIN = 1'b0;

  typedef struct packed {
    mode_t               mode;
    logic [VALUE_W-1:0]  value;
  } entry_state_t;

  typedef struct packed {
    mode_t                mode_now;
    logic [VALUE_W-1:0]   entry_value;
    logic                 display_refresh;
    logic                 command_valid;
    mode_t                command_mode;
    logic [CMDVAL_W-1:0]  command_value;
  } result_t;

endpackage

// ===== hw/rtl/pkce_step.sv =====
// ----------------------------------------------------------------------------
// pkce_step
// Next-state and result logic for one key: clear, commit, mode select and
// digit append.
// ----------------------------------------------------------------------------
module pkce_step
  import pkce_pkg::*;
(
  input  entry_state_t        cur,
  input  logic [KEY_W-1:0]    key,
  input  logic [VALUE_W-1:0]  pin_code,
  output entry_state_t        nxt,
  output result_t             res
);

  logic [VALUE_W+3:0] append_wide;
  logic [VALUE_W-1:0] appended;
  logic               refresh;
  logic               cmd_valid;
  mode_t              cmd_mode;
  logic [CMDVAL_W-1:0] cmd_value;

  // value * 10 + key as shift-add
  assign append_wide = {1'b0, cur.value, 3'b000} + {3'b000, cur.value, 1'b0} +
                       (VALUE_W+4)'(key);
  assign appended    = append_wide[VALUE_W-1:0];

  always_comb begin
    nxt       = cur;
    refresh   = 1'b1;
    cmd_valid = 1'b0;
    cmd_mode  = MODE_LOCKED;
    cmd_value = '0;
    priority if (key == KEY_HASH) begin
      nxt.value = '0;
      nxt.mode  = (cur.mode == MODE_LOCKED) ? MODE_LOCKED : MODE_IDLE;
    end else if (key == KEY_OK) begin
      nxt.value = '0;
      if (cur.mode == MODE_LOCKED) begin
        nxt.mode = (cur.value == pin_code) ? MODE_IDLE : MODE_LOCKED;
      end else begin
        cmd_valid = 1'b1;
        cmd_mode  = cur.mode;
        cmd_value = cur.value[CMDVAL_W-1:0];
        nxt.mode  = MODE_IDLE;
      end
    end else if (cur.mode == MODE_IDLE) begin
      unique case (key)
        KEY_UP:     nxt.mode = MODE_FWD;
        KEY_RIGHT:  nxt.mode = MODE_RIGHT;
        KEY_DOWN:   nxt.mode = MODE_BACK;
        KEY_LEFT:   nxt.mode = MODE_LEFT;
        KEY_SONAR:  nxt.mode = MODE_SONAR;
        KEY_SPRING: nxt.mode = MODE_SPRING;
        default:    refresh  = 1'b0;
      endcase
    end else if (cur.mode == MODE_SONAR || cur.mode == MODE_SPRING ||
                 key > KEY_DIG_MAX) begin
      refresh = 1'b0;
    end else if (cur.mode == MODE_LOCKED) begin
      if (cur.value < VALUE_W'(PIN_ROOM)) begin
        if (cur.value >= VALUE_W'(PIN_LAST)) begin
          // fourth digit commits the PIN on its own
          nxt.mode  = (appended == pin_code) ? MODE_IDLE : MODE_LOCKED;
          nxt.value = '0;
        end else begin
          nxt.value = appended;
        end
      end
    end else if (cur.value < VALUE_W'(CMD_ROOM)) begin
      nxt.value = appended;
    end
  end

  assign res.mode_now        = nxt.mode;
  assign res.entry_value     = nxt.value;
  assign res.display_refresh = refresh;
  assign res.command_valid   = cmd_valid;
  assign res.command_mode    = cmd_mode;
  assign res.command_value   = cmd_value;

endmodule

// ===== hw/rtl/pkce_outq.sv =====
// ----------------------------------------------------------------------------
// pkce_outq
// Two-entry result queue; keeps input accepting while a result waits.
// ----------------------------------------------------------------------------
module pkce_outq
  import pkce_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output result_t head_data
);

  result_t     q0_r, q0_nxt;
  result_t     q1_r, q1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    priority if (push && pop) begin
      q0_nxt = (cnt_r == 2'd1) ? push_data : q1_r;
      q1_nxt = push_data;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        q0_nxt = push_data;
      end else begin
        q1_nxt = push_data;
      end
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop) begin
      q0_nxt  = q1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign full       = cnt_r[1];
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = q0_r;

endmodule

// ===== hw/rtl/pin_locked_keypad_command_entry.sv =====
// ----------------------------------------------------------------------------
// pin_locked_keypad_command_entry
// Keypad front end: PIN unlock, mode select and numeric command entry.
// ----------------------------------------------------------------------------
// One key request is taken per clock. Each key is decoded against the current
// mode and entry value in combinational logic and its result lands in a
// two-entry output queue, so out_valid rises the cycle after acceptance and
// input keeps flowing while one result waits; in_ready drops only when both
// queue entries are held. The block starts locked: four PIN digits (leading
// zeros do not count) commit on their own against the pin_code register at
// byte address 0. OK commits a command when unlocked; hash clears the entry.
module pin_locked_keypad_command_entry
  import pkce_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KEY_W-1:0]    in_key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [MODE_W-1:0]   out_mode_now,
  output logic [VALUE_W-1:0]  out_entry_value,
  output logic                out_display_refresh,
  output logic                out_command_valid,
  output logic [MODE_W-1:0]   out_command_mode,
  output logic [CMDVAL_W-1:0] out_command_value,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  entry_state_t        state_r, state_nxt;
  logic [VALUE_W-1:0]  pin_r;
  result_t             step_res;
  result_t             head;
  logic                q_full;
  logic                push;
  logic                pop;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_PIN);
  assign prdata = (paddr[2] == REG_IDX_PIN) ? PDATA_W'(pin_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r <= '0;
    end else if (cfg_wr) begin
      pin_r <= pwdata[VALUE_W-1:0];
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  pkce_step u_step (
    .cur      (state_r),
    .key      (in_key),
    .pin_code (pin_r),
    .nxt      (state_nxt),
    .res      (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode  <= MODE_LOCKED;
      state_r.value <= '0;
    end else if (push) begin
      state_r <= state_nxt;
    end
  end

  pkce_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (step_res),
    .full       (q_full),
    .pop        (pop),
    .head_valid (out_valid),
    .head_data  (head)
  );

  assign out_mode_now        = head.mode_now;
  assign out_entry_value     = head.entry_value;
  assign out_display_refresh = head.display_refresh;
  assign out_command_valid   = head.command_valid;
  assign out_command_mode    = head.command_mode;
  assign out_command_value   = head.command_value;

`ifndef SYNTHESIS
  // locked entry never reaches a full PIN: the fourth digit commits and clears
  a_locked_short: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode == MODE_LOCKED |-> state_r.value < VALUE_W'(PIN_ROOM))
    else $error("locked entry holds a full PIN");

  // a committed command always leaves the block idle with an empty entry
  a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_valid |->
      out_mode_now == MODE_IDLE && out_entry_value == '0 &&
      out_command_mode != MODE_LOCKED)
    else $error("command result without return to idle");

  // an accepted key yields a result on the following cycle
  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid)
    else $error("accepted key produced no result");

  // state only moves on an accepted key
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !push |=> $stable(state_r))
    else $error("entry state changed without a key");
`endif

endmodule

// ===== test/tb_pin_locked_keypad_command_entry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pin_locked_keypad_command_entry
// Drives key requests into the keypad front end and checks every result
// against an in-bench decoder of the lock, mode select and command entry
// rules. Runs directed and random locked cases, a directed unlock pass, then
// random key sequences under several unlock codes and handshake stall patterns.
// ----------------------------------------------------------------------------
module tb_pin_locked_keypad_command_entry;
  import pkce_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [PADDR_W-1:0] PIN_ADDR = {REG_IDX_PIN, 2'b00};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KEY_W-1:0]    in_key = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [MODE_W-1:0]   out_mode_now;
  logic [VALUE_W-1:0]  out_entry_value;
  logic                out_display_refresh;
  logic                out_command_valid;
  logic [MODE_W-1:0]   out_command_mode;
  logic [CMDVAL_W-1:0] out_command_value;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // decoder shadow state
  mode_t               cur_mode = MODE_LOCKED;
  logic [VALUE_W-1:0]  cur_value = '0;
  logic [VALUE_W-1:0]  pin_shadow = '0;

  logic [KEY_W-1:0]    key_backlog[$];
  result_t             pending_results[$];
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  mismatches = 0;
  int                  cycles = 0;

  pin_locked_keypad_command_entry DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_key              (in_key),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_mode_now        (out_mode_now),
    .out_entry_value     (out_entry_value),
    .out_display_refresh (out_display_refresh),
    .out_command_valid   (out_command_valid),
    .out_command_mode    (out_command_mode),
    .out_command_value   (out_command_value),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one key to the shadow state and returns the result it produces.
  function automatic result_t decode_key(input logic [KEY_W-1:0] k);
    result_t r;
    r = '0;
    r.command_mode = MODE_LOCKED;
    r.display_refresh = 1'b1;
    if (k == KEY_HASH) begin
      if (cur_mode != MODE_LOCKED) cur_mode = MODE_IDLE;
      cur_value = '0;
    end else if (k == KEY_OK) begin
      if (cur_mode == MODE_LOCKED) begin
        if (cur_value == pin_shadow) cur_mode = MODE_IDLE;
      end else begin
        r.command_valid = 1'b1;
        r.command_mode  = cur_mode;
        r.command_value = cur_value[CMDVAL_W-1:0];
        cur_mode = MODE_IDLE;
      end
      cur_value = '0;
    end else if (cur_mode == MODE_IDLE) begin
      case (k)
        KEY_UP:     cur_mode = MODE_FWD;
        KEY_RIGHT:  cur_mode = MODE_RIGHT;
        KEY_DOWN:   cur_mode = MODE_BACK;
        KEY_LEFT:   cur_mode = MODE_LEFT;
        KEY_SONAR:  cur_mode = MODE_SONAR;
        KEY_SPRING: cur_mode = MODE_SPRING;
        default:    r.display_refresh = 1'b0;
      endcase
    end else if (cur_mode == MODE_SONAR || cur_mode == MODE_SPRING || k > KEY_DIG_MAX) begin
      r.display_refresh = 1'b0;
    end else if (cur_mode == MODE_LOCKED) begin
      if (cur_value < VALUE_W'(PIN_ROOM)) begin
        // three digits already held: this one completes the PIN and commits
        if (cur_value >= VALUE_W'(PIN_LAST)) begin
          cur_value = cur_value * VALUE_W'(RADIX) + VALUE_W'(k);
          if (cur_value == pin_shadow) cur_mode = MODE_IDLE;
          cur_value = '0;
        end else begin
          cur_value = cur_value * VALUE_W'(RADIX) + VALUE_W'(k);
        end
      end
    end else if (cur_value < VALUE_W'(CMD_ROOM)) begin
      cur_value = cur_value * VALUE_W'(RADIX) + VALUE_W'(k);
    end
    r.mode_now    = cur_mode;
    r.entry_value = cur_value;
    return r;
  endfunction

  task automatic check_field(input string fname, input int got, input int want);
    if (got != want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // key driver
  always @(posedge clk) begin
    logic taken;
    taken = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_results.push_back(decode_key(in_key));
        void'(key_backlog.pop_front());
        taken = 1'b1;
      end
      if (!in_valid || taken) begin
        if (key_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_key   <= key_backlog[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual mode %0d value %0d",
                   $time, out_mode_now, out_entry_value);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("mode_now", int'(out_mode_now), int'(want.mode_now));
          check_field("entry_value", int'(out_entry_value), int'(want.entry_value));
          check_field("display_refresh", int'(out_display_refresh),
                      int'(want.display_refresh));
          check_field("command_valid", int'(out_command_valid), int'(want.command_valid));
          check_field("command_mode", int'(out_command_mode), int'(want.command_mode));
          check_field("command_value", int'(out_command_value), int'(want.command_value));
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Waits until every queued key is taken and every result has come back.
  task automatic drain();
    do @(negedge clk);
    while (key_backlog.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // Register write; the unused upper data bits carry random junk.
  task automatic write_pin(input int pin);
    logic [PDATA_W-1:0] data;
    data = $urandom;
    data[VALUE_W-1:0] = VALUE_W'(pin);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PIN_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pin_shadow = data[VALUE_W-1:0];
  endtask

  // Mostly well-formed unlock and command sequences, some stray keys.
  task automatic queue_random_keys(input int n, input int pin);
    int pick;
    logic [KEY_W-1:0] sel;
    while (key_backlog.size() < n) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        key_backlog.push_back(KEY_HASH);
        if (pin > 9999 || pick < 6) begin
          repeat ($urandom_range(4, 1)) key_backlog.push_back(KEY_W'($urandom_range(9)));
          if ($urandom_range(1)) key_backlog.push_back(KEY_OK);
        end else if (pin >= PIN_ROOM) begin
          key_backlog.push_back(KEY_W'(pin / 1000));
          key_backlog.push_back(KEY_W'((pin / 100) % 10));
          key_backlog.push_back(KEY_W'((pin / 10) % 10));
          key_backlog.push_back(KEY_W'(pin % 10));
        end else begin
          // short code: no leading zeros, commit with OK
          if (pin >= 100) key_backlog.push_back(KEY_W'(pin / 100));
          if (pin >= 10) key_backlog.push_back(KEY_W'((pin / 10) % 10));
          if (pin != 0) key_backlog.push_back(KEY_W'(pin % 10));
          key_backlog.push_back(KEY_OK);
        end
      end else if (pick < 85) begin
        case ($urandom_range(9))
          0, 1:    sel = KEY_UP;
          2, 3:    sel = KEY_RIGHT;
          4, 5:    sel = KEY_DOWN;
          6, 7:    sel = KEY_LEFT;
          8:       sel = KEY_SONAR;
          default: sel = KEY_SPRING;
        endcase
        key_backlog.push_back(sel);
        repeat ($urandom_range(4)) key_backlog.push_back(KEY_W'($urandom_range(9)));
        if ($urandom_range(9) == 0) key_backlog.push_back(KEY_W'($urandom_range(15)));
        key_backlog.push_back(($urandom_range(4) == 0) ? KEY_HASH : KEY_OK);
      end else begin
        repeat ($urandom_range(3, 1)) key_backlog.push_back(KEY_W'($urandom_range(15)));
      end
    end
  endtask

  initial begin
    int pin;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // locked cases; a code above 9999 can never match
    write_pin(16383);
    key_backlog = '{KEY_UP, 4'd0, KEY_OK, 4'd4, KEY_HASH,
                    4'd9, 4'd9, 4'd9, 4'd9, KEY_OK};
    drain();
    stall_pct = 49;
    queue_random_keys(150, 16383);
    drain();

    // unlock by auto-commit, then mode select and command entry
    stall_pct = 0;
    write_pin(1203);
    key_backlog = '{4'd1, 4'd2, 4'd0, 4'd3, 4'd3, KEY_UP,
                    4'd9, 4'd9, 4'd9, 4'd9, KEY_LEFT, KEY_OK, KEY_OK,
                    KEY_RIGHT, 4'd0, KEY_HASH, KEY_SONAR, 4'd3, KEY_OK,
                    KEY_SPRING, KEY_HASH};
    drain();

    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: begin pin = 0;                          send_idle_pct = 0;  stall_pct = 0;  end
        2: begin pin = 9999;                       send_idle_pct = 49; stall_pct = 0;  end
        3: begin pin = $urandom_range(999);        send_idle_pct = 0;  stall_pct = 49; end
        4: begin pin = $urandom_range(9999, 1000); send_idle_pct = 25; stall_pct = 25; end
        default: begin
          pin = $urandom_range(16383);
          send_idle_pct = 49;
          stall_pct = 25;
        end
      endcase
      write_pin(pin);
      queue_random_keys(300, pin);
      drain();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
